// File: hw/rtl/present128_block_encrypt_top_assert.svh
// assertion macros for the present-128 encryption block
// used by the port checker; no other dependencies
`ifndef PRESENT128_BLOCK_ENCRYPT_TOP_ASSERT_SVH
`define PRESENT128_BLOCK_ENCRYPT_TOP_ASSERT_SVH

// property checked only outside reset
`define P128_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define P128_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/p128_pkg.sv
// shared types, constants and round functions of the present-128 encryptor
// no dependencies
package p128_pkg;

   localparam int P128_ROUNDS    = 31;
   localparam int P128_BLOCK_W   = 64;
   localparam int P128_KEY_HALF_W = 64;
   localparam int P128_ROUND_W   = 5;

   // configuration register indexes
   typedef enum logic [0:0] {
      CSR_KEY_HIGH = 1'b0,
      CSR_KEY_LOW  = 1'b1
   } p128_csr_index_type;

   // data carried from one round cell to the next
   typedef struct packed {
      logic [P128_BLOCK_W-1:0]    block;
      logic [P128_KEY_HALF_W-1:0] key_hi;
      logic [P128_KEY_HALF_W-1:0] key_lo;
   } p128_stage_type;

   // 4-bit substitution box
   function automatic logic [3:0] p128_sbox(input logic [3:0] nib);
      logic [3:0] r;
      case (nib)
         4'h0: r = 4'hc;
         4'h1: r = 4'h5;
         4'h2: r = 4'h6;
         4'h3: r = 4'hb;
         4'h4: r = 4'h9;
         4'h5: r = 4'h0;
         4'h6: r = 4'ha;
         4'h7: r = 4'hd;
         4'h8: r = 4'h3;
         4'h9: r = 4'he;
         4'ha: r = 4'hf;
         4'hb: r = 4'h8;
         4'hc: r = 4'h4;
         4'hd: r = 4'h7;
         4'he: r = 4'h1;
         4'hf: r = 4'h2;
         default: r = 4'h0;
      endcase
      return r;
   endfunction

   // substitution layer over all sixteen nibbles
   function automatic logic [P128_BLOCK_W-1:0] p128_sub_layer(
      input logic [P128_BLOCK_W-1:0] s);
      logic [P128_BLOCK_W-1:0] r;
      for (int n = 0; n < P128_BLOCK_W / 4; n++) begin
         r[4*n +: 4] = p128_sbox(s[4*n +: 4]);
      end
      return r;
   endfunction

   // bit permutation: bit j moves to 16*(j mod 4) + j/4
   function automatic logic [P128_BLOCK_W-1:0] p128_perm_layer(
      input logic [P128_BLOCK_W-1:0] s);
      logic [P128_BLOCK_W-1:0] r;
      for (int j = 0; j < P128_BLOCK_W; j++) begin
         r[16 * (j % 4) + j / 4] = s[j];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/present128_block_encrypt_top.sv
// present-128 block encryptor: key registers and a chain of 31 round cells
// depends on p128_pkg and p128_round_cell
//
// Usage:
//   Write the key through the csr port while the block is idle: index 0
//   takes key bits 127..64, index 1 takes bits 63..0. Writes take effect at
//   the clock edge where csr_we is high; other indexes do not exist.
//   Plaintext requests enter on req_* and ciphertexts leave on rsp_* in the
//   same order, one per request.
//   Each request passes through every round cell in turn, one round per
//   cell, each round cell registering its block and its round key.
//   rsp_tvalid rises once the block is held in the last cell's register.
//   The final key XOR is applied on the way out of the last cell.
//   Throughput is one block per cycle while rsp_tready stays high.
//   When the receiver stalls the last cell holds its result; upstream cells
//   keep filling empty slots, so requests are still taken until every cell
//   holds a block. Ready ripples back through the chain of cells.
//   Reset empties every cell and clears both key registers to zero.
module present128_block_encrypt_top
   import p128_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // configuration write port
   input  logic                       csr_we,
   input  logic [0:0]                 csr_index,
   input  logic [P128_KEY_HALF_W-1:0] csr_wdata,
   // request channel
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [P128_BLOCK_W-1:0]    req_tdata,   // [63:0] plaintext
   // response channel
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [P128_BLOCK_W-1:0]    rsp_tdata    // [63:0] ciphertext
);

   logic [P128_KEY_HALF_W-1:0] key_hi_ff, key_hi_in;
   logic [P128_KEY_HALF_W-1:0] key_lo_ff, key_lo_in;

   p128_stage_type link_data  [0:P128_ROUNDS];
   logic           link_valid [0:P128_ROUNDS];
   logic           link_ready [0:P128_ROUNDS];

   // key register writes
   always_comb begin
      key_hi_in = key_hi_ff;
      key_lo_in = key_lo_ff;
      if (csr_we) begin
         case (p128_csr_index_type'(csr_index))
            CSR_KEY_HIGH: key_hi_in = csr_wdata;
            CSR_KEY_LOW:  key_lo_in = csr_wdata;
            default: begin
               key_hi_in = key_hi_ff;
               key_lo_in = key_lo_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else begin
         key_hi_ff <= key_hi_in;
         key_lo_ff <= key_lo_in;
      end
   end

   // chain input
   assign link_valid[0]        = req_tvalid;
   assign req_tready           = link_ready[0];
   assign link_data[0].block   = req_tdata;
   assign link_data[0].key_hi  = key_hi_ff;
   assign link_data[0].key_lo  = key_lo_ff;

   // round cells
   for (genvar i = 0; i < P128_ROUNDS; i++) begin : g_round
      p128_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .round_num (P128_ROUND_W'(i + 1)),
         .up_valid  (link_valid[i]),
         .up_ready  (link_ready[i]),
         .up_data   (link_data[i]),
         .dn_valid  (link_valid[i+1]),
         .dn_ready  (link_ready[i+1]),
         .dn_data   (link_data[i+1])
      );
   end

   // chain output with the final key addition
   assign link_ready[P128_ROUNDS] = rsp_tready;
   assign rsp_tvalid = link_valid[P128_ROUNDS];
   assign rsp_tdata  = link_data[P128_ROUNDS].block ^ link_data[P128_ROUNDS].key_hi;

endmodule

// File: hw/rtl/p128_round_cell.sv
// one round cell of the present-128 pipeline: round function and key update
// depends on p128_pkg
module p128_round_cell
   import p128_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic [P128_ROUND_W-1:0] round_num,
   input  logic                    up_valid,
   output logic                    up_ready,
   input  p128_stage_type          up_data,
   output logic                    dn_valid,
   input  logic                    dn_ready,
   output p128_stage_type          dn_data
);

   logic            valid_ff, valid_in;
   p128_stage_type  data_ff, data_in;
   logic [2*P128_KEY_HALF_W-1:0] key_cur, key_rot, key_next;

   // cell takes a request when empty or when its contents move on
   assign up_ready = !valid_ff || dn_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;

   // round function and key schedule step
   always_comb begin
      key_cur  = {up_data.key_hi, up_data.key_lo};
      key_rot  = {key_cur[2*P128_KEY_HALF_W-62:0], key_cur[2*P128_KEY_HALF_W-1 -: 61]};
      key_next = key_rot;
      key_next[127:124] = p128_sbox(key_rot[127:124]);
      key_next[123:120] = p128_sbox(key_rot[123:120]);
      key_next[66:62]   = key_rot[66:62] ^ round_num;
      data_in.block  = p128_perm_layer(p128_sub_layer(up_data.block ^ up_data.key_hi));
      data_in.key_hi = key_next[2*P128_KEY_HALF_W-1:P128_KEY_HALF_W];
      data_in.key_lo = key_next[P128_KEY_HALF_W-1:0];
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (up_valid && up_ready) begin
         data_ff <= data_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

endmodule

// File: hw/rtl/p128_checker.sv
// port checker for the present-128 encryptor, bound to the top level
// depends on present128_block_encrypt_top_assert.svh
`include "present128_block_encrypt_top_assert.svh"

module p128_checker
   import p128_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    req_tready,
   input logic                    rsp_tvalid,
   input logic                    rsp_tready,
   input logic [P128_BLOCK_W-1:0] rsp_tdata
);

   // reset empties the whole chain
   `P128_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_tvalid, "response valid after reset")

   // a free output slot lets ready ripple back to the request side
   `P128_ASSERT(a_ready_ripple, clock, reset,
      (!rsp_tvalid || rsp_tready) |-> req_tready, "request not ready with output free")

   // a stalled response keeps its value
   `P128_ASSERT(a_rsp_hold, clock, reset,
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)),
      "stalled response changed")

   // no response is valid right after reset is released
   `P128_ASSERT(a_latency_floor, clock, reset,
      $past(reset) |-> !rsp_tvalid, "response too soon after reset")

endmodule

bind present128_block_encrypt_top p128_checker u_p128_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
